@@ design/gcoa_pkg.sv @@
`timescale 1ns / 1ps

package gcoa_pkg;

	localparam int OP_W      = 2;
	localparam int IDX_W     = 8;
	localparam int SPAN_W    = 5;
	localparam int DIM_W     = 5;
	localparam int POS_W     = 8;
	localparam int RC_W      = 4;
	// row and column walk counters: anchor up to 255 plus a span of up to 31
	localparam int CUR_W     = 9;
	// rows * columns in use, each at most 31
	localparam int TOT_W     = 10;
	localparam int REG_IDX_W = 2;
	localparam int CFG_W     = 5;
	localparam int S_DATA_W  = 24;
	localparam int M_DATA_W  = 16;

	localparam logic [REG_IDX_W-1:0] REG_ROWS         = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLUMNS      = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COLUMN_MAJOR = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 2'd0,
		OP_RESERVE = 2'd1,
		OP_NEXT    = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOAD,
		ST_CHECK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic rd;
		logic wr;
		logic clr;
	} map_ctl_t;

	typedef struct packed {
		logic            ok;
		logic [POS_W-1:0] position;
		logic [RC_W-1:0]  cell_row;
		logic [RC_W-1:0]  cell_column;
	} result_t;

endpackage

@@ design/grid_cell_occupancy_allocator.sv @@
`timescale 1ns / 1ps

// Grid cell occupancy allocator.
// Requests enter on the s_ stream: s_tuser carries the operation (clear, reserve, next),
// s_tdata the anchor index and spans. Each request gives one result on the m_ stream:
// m_tuser is the ok flag, m_tdata the position, row and column.
// Configuration (rows, columns, index order) is written through cfg_we/cfg_addr/cfg_wdata
// while the block is idle; a write that changes a value frees the whole map.
// Steps, from acceptance to the result register:
//   clear    goes direct to the result, as do next on a full grid and an unused code
//   reserve  an 8-step divider maps the anchor to row and column, then each cell tried
//            is one read of a map row and, if the cell is free, its write-back; a cell
//            outside the grid ends the walk without a read
//   next     scans from the pointer through the single row port of the map memory,
//            each cell a registered read, then a write-back of the cell found free
// One request is in work at a time; s_tready is high only while idle, from the cycle
// after the result register loads.
// Reset frees every cell at once through per-row valid bits, zeroes the pointer and
// loads rows = 1, columns = 1, row-major order. No clearing pass is needed.
// While the receiver stalls the result register holds; the next request is still
// accepted and worked on, and waits for the register to empty before it is shown.
module grid_cell_occupancy_allocator #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLUMNS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// s_tdata: cell_index [7:0], row_span [12:8], col_span [17:13], zero fill above
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [gcoa_pkg::S_DATA_W-1:0]  s_tdata,
	// s_tuser: operation [1:0]
	input  logic [gcoa_pkg::OP_W-1:0]      s_tuser,
	// m_tdata: position [7:0], cell_row [11:8], cell_column [15:12]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [gcoa_pkg::M_DATA_W-1:0]  m_tdata,
	// m_tuser: ok [0]
	output logic                           m_tuser,
	input  logic                           cfg_we,
	input  logic [gcoa_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [gcoa_pkg::CFG_W-1:0]     cfg_wdata
);
	import gcoa_pkg::*;

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	// configured dimensions are 5 bits wide, so they never pass 31
	localparam int UR = (MAX_ROWS < 31) ? MAX_ROWS : 31;
	localparam int UC = (MAX_COLUMNS < 31) ? MAX_COLUMNS : 31;
	localparam int PW = $clog2(UR * UC + 1);

	// configuration
	logic [DIM_W-1:0] grid_rows_q;
	logic [DIM_W-1:0] grid_columns_q;
	logic             column_major_q;
	logic             cfg_change;
	logic [DIM_W-1:0] rows;
	logic [DIM_W-1:0] cols;
	logic [TOT_W-1:0] total;

	// sequencer and datapath
	state_t           st_q, st_d;
	op_t              op_q;
	logic [SPAN_W-1:0] rs_q, cs_q;
	logic [CUR_W-1:0] c0_q, end_r_q, end_c_q, cur_r_q, cur_c_q;
	logic [PW-1:0]    ptr_q;
	logic [DIM_W-1:0] pr_q, pc_q;
	logic [DIM_W-1:0] pr_n, pc_n;
	result_t          res_q, out_q;
	logic             out_valid_q;

	logic             accept;
	op_t              in_op;
	logic             is_next;
	logic             ptr_full, nxt_full;
	logic             rsv_oor, rsv_last, zero_span, out_free;
	logic [CUR_W-1:0] row_sel, col_sel;
	logic [CUR_W-1:0] r0_n, c0_n;

	map_ctl_t         map_ctl;
	logic             cell_free;
	logic             div_start, div_busy, div_done;
	logic [IDX_W-1:0] div_quo;
	logic [DIM_W-1:0] div_rem;

	// saturate the dimensions in use to 1..MAX
	always_comb begin
		if (grid_rows_q == '0) begin
			rows = DIM_W'(1);
		end else if (32'(grid_rows_q) > MAX_ROWS) begin
			rows = DIM_W'(MAX_ROWS);
		end else begin
			rows = grid_rows_q;
		end
		if (grid_columns_q == '0) begin
			cols = DIM_W'(1);
		end else if (32'(grid_columns_q) > MAX_COLUMNS) begin
			cols = DIM_W'(MAX_COLUMNS);
		end else begin
			cols = grid_columns_q;
		end
	end

	assign total = TOT_W'(rows) * TOT_W'(cols);

	always_comb begin
		cfg_change = 1'b0;
		if (cfg_we) begin
			unique case (cfg_addr)
				REG_ROWS:         cfg_change = cfg_wdata != grid_rows_q;
				REG_COLUMNS:      cfg_change = cfg_wdata != grid_columns_q;
				REG_COLUMN_MAJOR: cfg_change = cfg_wdata[0] != column_major_q;
				default:          cfg_change = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q    <= DIM_W'(1);
			grid_columns_q <= DIM_W'(1);
			column_major_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ROWS:         grid_rows_q    <= cfg_wdata;
				REG_COLUMNS:      grid_columns_q <= cfg_wdata;
				REG_COLUMN_MAJOR: column_major_q <= cfg_wdata[0];
				default:          ;
			endcase
		end
	end

	// status used by the sequencer
	assign accept    = s_tvalid && s_tready;
	assign in_op     = op_t'(s_tuser);
	assign is_next   = op_q == OP_NEXT;
	assign ptr_full  = TOT_W'(ptr_q) >= total;
	assign nxt_full  = TOT_W'(ptr_q) + TOT_W'(1) >= total;
	assign rsv_oor   = cur_r_q >= CUR_W'(rows) || cur_c_q >= CUR_W'(cols);
	assign rsv_last  = (cur_c_q + CUR_W'(1) == end_c_q) && (cur_r_q + CUR_W'(1) == end_r_q);
	assign zero_span = rs_q == '0 || cs_q == '0;
	assign out_free  = !out_valid_q || m_tready;
	assign row_sel   = is_next ? CUR_W'(pr_q) : cur_r_q;
	assign col_sel   = is_next ? CUR_W'(pc_q) : cur_c_q;
	assign r0_n      = column_major_q ? CUR_W'(div_rem) : CUR_W'(div_quo);
	assign c0_n      = column_major_q ? CUR_W'(div_quo) : CUR_W'(div_rem);

	// step the scan pointer one cell in index order
	always_comb begin
		pr_n = pr_q;
		pc_n = pc_q;
		if (column_major_q) begin
			if (pr_q == rows - DIM_W'(1)) begin
				pr_n = '0;
				pc_n = pc_q + DIM_W'(1);
			end else begin
				pr_n = pr_q + DIM_W'(1);
			end
		end else begin
			if (pc_q == cols - DIM_W'(1)) begin
				pc_n = '0;
				pr_n = pr_q + DIM_W'(1);
			end else begin
				pc_n = pc_q + DIM_W'(1);
			end
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					unique case (in_op)
						OP_CLEAR:   st_d = ST_EMIT;
						OP_RESERVE: st_d = ST_DIV;
						OP_NEXT:    st_d = ptr_full ? ST_EMIT : ST_LOAD;
						default:    st_d = ST_EMIT;
					endcase
				end
			end
			ST_DIV: begin
				if (div_done) begin
					st_d = zero_span ? ST_EMIT : ST_LOAD;
				end
			end
			ST_LOAD: begin
				st_d = (!is_next && rsv_oor) ? ST_EMIT : ST_CHECK;
			end
			ST_CHECK: begin
				if (is_next) begin
					st_d = (cell_free || nxt_full) ? ST_EMIT : ST_LOAD;
				end else begin
					st_d = (!cell_free || rsv_last) ? ST_EMIT : ST_LOAD;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready    = st_q == ST_IDLE;
		div_start   = st_q == ST_IDLE && s_tvalid && in_op == OP_RESERVE;
		map_ctl.rd  = st_q == ST_LOAD && !(!is_next && rsv_oor);
		map_ctl.wr  = st_q == ST_CHECK && cell_free;
		map_ctl.clr = (accept && in_op == OP_CLEAR) || cfg_change;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ptr_q       <= '0;
			pr_q        <= '0;
			pc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (map_ctl.clr) begin
				ptr_q <= '0;
				pr_q  <= '0;
				pc_q  <= '0;
			end else if (st_q == ST_CHECK && is_next) begin
				ptr_q <= ptr_q + PW'(1);
				pr_q  <= pr_n;
				pc_q  <= pc_n;
			end
			// a new result takes precedence over the handshake of the old one
			if (st_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request payload, walk counters and pending result
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (accept) begin
					op_q  <= in_op;
					rs_q  <= s_tdata[IDX_W +: SPAN_W];
					cs_q  <= s_tdata[IDX_W + SPAN_W +: SPAN_W];
					res_q <= '{ok: in_op == OP_CLEAR, position: '0,
						cell_row: '0, cell_column: '0};
				end
			end
			ST_DIV: begin
				if (div_done) begin
					c0_q    <= c0_n;
					cur_r_q <= r0_n;
					cur_c_q <= c0_n;
					end_r_q <= r0_n + CUR_W'(rs_q);
					end_c_q <= c0_n + CUR_W'(cs_q);
					res_q   <= '{ok: 1'b1, position: '0,
						cell_row: r0_n[RC_W-1:0], cell_column: c0_n[RC_W-1:0]};
				end
			end
			ST_LOAD: begin
				if (!is_next && rsv_oor) begin
					res_q.ok <= 1'b0;
				end
			end
			ST_CHECK: begin
				if (is_next) begin
					if (cell_free) begin
						res_q <= '{ok: 1'b1, position: POS_W'(ptr_q),
							cell_row: pr_q[RC_W-1:0], cell_column: pc_q[RC_W-1:0]};
					end
				end else if (!cell_free) begin
					res_q.ok <= 1'b0;
				end else if (!rsv_last) begin
					// advance column by column, wrap to the anchor column on a new row
					if (cur_c_q + CUR_W'(1) == end_c_q) begin
						cur_c_q <= c0_q;
						cur_r_q <= cur_r_q + CUR_W'(1);
					end else begin
						cur_c_q <= cur_c_q + CUR_W'(1);
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end

	gcoa_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (s_tdata[IDX_W-1:0]),
		.divisor   (column_major_q ? rows : cols),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	gcoa_cell_map #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLUMNS (MAX_COLUMNS),
		.AW          (AW),
		.CW          (CW)
	) u_cell_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (map_ctl),
		.addr      (row_sel[AW-1:0]),
		.col       (col_sel[CW-1:0]),
		.cell_free (cell_free)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.ok;
	assign m_tdata  = {out_q.cell_column, out_q.cell_row, out_q.position};

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		TOT_W'(ptr_q) <= total)
		else $error("scan pointer beyond the grid");

	a_next_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CHECK && op_q == OP_NEXT) |-> (pr_q < rows && pc_q < cols))
		else $error("scan probes a cell outside the grid");

	a_rsv_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_CHECK && op_q == OP_RESERVE) |->
		(cur_r_q < CUR_W'(rows) && cur_c_q < CUR_W'(cols)))
		else $error("reserve marks a cell outside the grid");

	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("divider still busy while idle");

endmodule

@@ design/gcoa_divider.sv @@
`timescale 1ns / 1ps

module gcoa_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [gcoa_pkg::IDX_W-1:0] dividend,
	input  logic [gcoa_pkg::DIM_W-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [gcoa_pkg::IDX_W-1:0] quotient,
	output logic [gcoa_pkg::DIM_W-1:0] remainder
);
	import gcoa_pkg::*;

	localparam int CNT_W = $clog2(IDX_W);

	logic [IDX_W-1:0] quo_q;
	logic [DIM_W-1:0] rem_q;
	logic [DIM_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIM_W:0]   trial;
	logic             ge;
	logic [DIM_W:0]   diff;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, quo_q[IDX_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(IDX_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(IDX_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[IDX_W-2:0], ge};
			rem_q <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

@@ design/gcoa_cell_map.sv @@
`timescale 1ns / 1ps

module gcoa_cell_map #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLUMNS = 16,
	parameter int AW          = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	parameter int CW          = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gcoa_pkg::map_ctl_t ctl,
	input  logic [AW-1:0]      addr,
	input  logic [CW-1:0]      col,
	output logic               cell_free
);
	import gcoa_pkg::*;

	logic [MAX_COLUMNS-1:0] mem [MAX_ROWS];
	logic [MAX_ROWS-1:0]    row_valid_q;
	logic [MAX_COLUMNS-1:0] rdata_s1;
	logic                   rvalid_s1;
	logic [MAX_COLUMNS-1:0] row_eff;
	logic [MAX_COLUMNS-1:0] wr_row;

	// a row never written since the last clear reads as all free
	assign row_eff   = rvalid_s1 ? rdata_s1 : '1;
	assign cell_free = row_eff[col];

	always_comb begin
		for (int j = 0; j < MAX_COLUMNS; j++) begin
			wr_row[j] = row_eff[j] & (CW'(j) != col);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rdata_s1 <= mem[addr];
		end
		if (ctl.wr) begin
			mem[addr] <= wr_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_s1   <= 1'b0;
		end else begin
			if (ctl.clr) begin
				row_valid_q <= '0;
			end else if (ctl.wr) begin
				row_valid_q[addr] <= 1'b1;
			end
			if (ctl.rd) begin
				rvalid_s1 <= row_valid_q[addr];
			end
		end
	end

endmodule
